FILE: src/mfpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpc_pkg: shared types and constants
// Request and response payloads, memory command and serializer load record
// for the frame to page-column transpose.
// ----------------------------------------------------------------------------
package mfpc_pkg;

   localparam int PAGE_ROWS   = 8;
   localparam int STRIP_ROWS  = PAGE_ROWS - 1;
   localparam int STRIP_W     = STRIP_ROWS * 8;
   localparam int POS_FIELD_W = 4;

   // register indexes on the csr port
   localparam logic CSR_WIDTH_BYTES = 1'b0;
   localparam logic CSR_HEIGHT_ROWS = 1'b1;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] column_byte;
      logic [6:0] column_index;
      logic [2:0] page_index;
      logic       last_of_run;
      logic       end_of_frame;
   } rsp_type;

   // one access to the strip store per accepted request
   typedef struct packed {
      logic                   wr_en;
      logic                   rd_en;
      logic [POS_FIELD_W-1:0] addr;
      logic [2:0]             lane;
      logic [7:0]             data;
   } mem_cmd_type;

   // what the serializer needs for one final-row request
   typedef struct packed {
      logic                   en;
      logic [7:0]             pix;
      logic [2:0]             sub;
      logic [POS_FIELD_W-1:0] pos;
      logic [2:0]             page;
      logic                   eof;
   } load_type;

endpackage

FILE: src/mfpc_strip_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpc_strip_mem: strip store
// One entry per byte position holding rows 0..6 of the current page, byte
// lane writes and a registered read port.
// ----------------------------------------------------------------------------
module mfpc_strip_mem #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  mfpc_pkg::mem_cmd_type        cmd,
   output logic [mfpc_pkg::STRIP_W-1:0] rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [mfpc_pkg::STRIP_W-1:0] mem [DEPTH];
   logic [mfpc_pkg::STRIP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         for (int l = 0; l < mfpc_pkg::STRIP_ROWS; l++) begin
            if (cmd.lane == 3'(l)) begin
               mem[cmd.addr[AW-1:0]][l*8 +: 8] <= cmd.data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mfpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpc_ctrl: position tracking and configuration
// Holds the geometry registers and the row/byte position, and turns each
// accepted request into a strip write or a strip read plus serializer load.
// ----------------------------------------------------------------------------
module mfpc_ctrl #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [6:0]            csr_wdata,
   input  logic                  accept,
   input  mfpc_pkg::req_type     req,
   output mfpc_pkg::mem_cmd_type cmd,
   output mfpc_pkg::load_type    load
);

   localparam int MAXW_B = MAX_WIDTH / 8;
   localparam int POS_W  = (MAXW_B > 1) ? $clog2(MAXW_B) : 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT);

   logic [4:0]       width_ff, width_in;
   logic [6:0]       height_ff, height_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [4:0]       eff_w;
   logic [6:0]       eff_h;
   logic             restart;
   logic [POS_W-1:0] pos;
   logic [ROW_W-1:0] row;
   logic [2:0]       sub;
   logic             last_frame_row;
   logic             final_row;
   logic [4:0]       pos_inc;
   logic [6:0]       row_inc;

   // clamp the geometry registers into range
   always_comb begin
      eff_w = width_ff;
      if (width_ff == 5'd0) eff_w = 5'd1;
      else if (width_ff > 5'(MAXW_B)) eff_w = 5'(MAXW_B);
      eff_h = height_ff;
      if (height_ff == 7'd0) eff_h = 7'd1;
      else if (height_ff > 7'(MAX_HEIGHT)) eff_h = 7'(MAX_HEIGHT);
   end

   always_comb begin
      restart = req.frame_start || (7'(row_ff) >= eff_h) || (5'(pos_ff) >= eff_w);
      pos     = restart ? '0 : pos_ff;
      row     = restart ? '0 : row_ff;
      sub     = row[2:0];
      row_inc = 7'(row) + 7'd1;
      pos_inc = 5'(pos) + 5'd1;
      last_frame_row = (row_inc == eff_h);
      final_row      = (sub == 3'(mfpc_pkg::PAGE_ROWS - 1)) || last_frame_row;
   end

   always_comb begin
      pos_in = pos_ff;
      row_in = row_ff;
      if (accept) begin
         if (pos_inc >= eff_w) begin
            pos_in = '0;
            row_in = (row_inc >= eff_h) ? '0 : ROW_W'(row_inc);
         end else begin
            pos_in = POS_W'(pos_inc);
            row_in = row;
         end
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            mfpc_pkg::CSR_WIDTH_BYTES: width_in  = csr_wdata[4:0];
            mfpc_pkg::CSR_HEIGHT_ROWS: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 5'd16;
         height_ff <= 7'd64;
         pos_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         pos_ff    <= pos_in;
         row_ff    <= row_in;
      end
   end

   // non-final rows go into the strip, the final row reads it back
   always_comb begin
      cmd.wr_en = accept && !final_row;
      cmd.rd_en = accept && final_row;
      cmd.addr  = mfpc_pkg::POS_FIELD_W'(pos);
      cmd.lane  = sub;
      cmd.data  = req.pixel_byte;

      load.en   = accept && final_row;
      load.pix  = req.pixel_byte;
      load.sub  = sub;
      load.pos  = mfpc_pkg::POS_FIELD_W'(pos);
      load.page = 3'(row >> 3);
      load.eof  = last_frame_row && (pos_inc == eff_w);
   end

endmodule

FILE: src/mfpc_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfpc_serializer: column byte sequencer
// Emits the eight column bytes of one final-row request, one per beat, from
// the strip word read back and the final row's pixel byte.
// ----------------------------------------------------------------------------
module mfpc_serializer (
   input  logic                         clock,
   input  logic                         reset,
   input  mfpc_pkg::load_type           load,
   input  logic [mfpc_pkg::STRIP_W-1:0] strip,
   input  logic                         rsp_stall,
   output logic                         rsp_valid,
   output mfpc_pkg::rsp_type            rsp_data,
   output logic                         free
);

   logic       busy_ff, busy_in;
   logic [2:0] beat_ff, beat_in;
   logic [7:0] pix_ff;
   logic [2:0] sub_ff;
   logic [mfpc_pkg::POS_FIELD_W-1:0] pos_ff;
   logic [2:0] page_ff;
   logic       eof_ff;
   logic       last_beat;
   logic [7:0] col;

   assign last_beat = (beat_ff == 3'd7);
   assign free      = !busy_ff || (last_beat && !rsp_stall);

   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (load.en) begin
         busy_in = 1'b1;
         beat_in = 3'd0;
      end else if (busy_ff && !rsp_stall) begin
         busy_in = !last_beat;
         beat_in = beat_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.en) begin
         pix_ff  <= load.pix;
         sub_ff  <= load.sub;
         pos_ff  <= load.pos;
         page_ff <= load.page;
         eof_ff  <= load.eof;
      end
   end

   // rows below the final one from the strip, final row on top, rest zero
   always_comb begin
      col = '0;
      for (int k = 0; k < mfpc_pkg::STRIP_ROWS; k++) begin
         if (3'(k) < sub_ff) col[k] = strip[6'(k*8) + 6'(beat_ff)];
      end
      for (int k = 0; k < mfpc_pkg::PAGE_ROWS; k++) begin
         if (3'(k) == sub_ff) col[k] = pix_ff[beat_ff];
      end
   end

   assign rsp_valid             = busy_ff;
   assign rsp_data.column_byte  = col;
   assign rsp_data.column_index = {pos_ff, beat_ff};
   assign rsp_data.page_index   = page_ff;
   assign rsp_data.last_of_run  = last_beat;
   assign rsp_data.end_of_frame = eof_ff && last_beat;

endmodule

FILE: src/mono_frame_to_page_columns.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_frame_to_page_columns: row-major frame to page-column transpose
// Turns a 1 bpp frame in row-major bytes into column bytes for an 8-row page
// display, buffering each page's upper rows in a strip store.
// ----------------------------------------------------------------------------
// usage
//  - req channel carries one frame byte per request (valid/stall); frame_start
//    puts the position back at row 0, byte 0
//  - bytes of rows that are not the last of a page (or of the frame) are
//    written into the strip store and give no response
//  - a byte of a page's last row reads its strip entry; eight column bytes
//    follow on the rsp channel, the first in the cycle after the request
//  - strip-row requests are taken one per cycle while the serializer is
//    free; a final-row request occupies the serializer until its eight
//    column beats have left
//  - the next request is taken in the cycle the eighth beat leaves
//  - rsp_stall freezes the current beat; req_stall rises while beats are
//    pending, so nothing is dropped
//  - csr port: index 0 width_bytes, index 1 height_rows, written while idle
//  - reset clears position and geometry (16 bytes x 64 rows); the strip
//    store is not cleared, every entry is written before a page reads it
// ----------------------------------------------------------------------------
module mono_frame_to_page_columns #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mfpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mfpc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [6:0]        csr_wdata
);

   localparam int DEPTH = MAX_WIDTH / 8;

   logic                         accept;
   logic                         ser_free;
   mfpc_pkg::mem_cmd_type        mem_cmd;
   mfpc_pkg::load_type           load;
   logic [mfpc_pkg::STRIP_W-1:0] strip_rd;

   // stall while column beats are still owed, except on the last one leaving
   assign req_stall = !ser_free;
   assign accept    = req_valid && !req_stall;

   mfpc_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req       (req_data),
      .cmd       (mem_cmd),
      .load      (load)
   );

   // one access per cycle: a strip write always lands in an earlier cycle than
   // the read of the same entry, so no forwarding is needed
   mfpc_strip_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (strip_rd)
   );

   // read data lands with the load and holds until the next final-row read,
   // which can only come once the serializer is free
   mfpc_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .strip     (strip_rd),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (ser_free)
   );

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("strip store read and write in one cycle");

   a_idle_takes_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no response pending");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_run |=> rsp_valid)
      else $error("column run ended early");

   a_eof_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_frame |-> rsp_data.last_of_run)
      else $error("end of frame not on last beat");

endmodule
